// ===== rtl/core/rpa_pkg.sv =====
// Shared constants, CORDIC arctangent table and width helpers for the axis rotation block.
`timescale 1ns / 1ps
`default_nettype none
package rpa_pkg;

  localparam int TRIG_Q    = 26;  // fraction bits of sin, cos and coefficients
  localparam int MAX_STEPS = 32;
  localparam int PTW       = 32;  // point and result coordinate width
  localparam int AW        = 18;  // axis component width
  localparam int XW        = 33;  // CORDIC x / y width, Q30
  localparam int TW        = 36;  // CORDIC angle width, Q30
  localparam int DIRW      = 35;  // clamped remainder width
  localparam int CW        = 30;  // Q26 sin / cos width
  localparam int MW        = 30;  // clamped coefficient width

  localparam logic signed [TW-1:0]   PI_Q30      = 36'sd3373259426;
  localparam logic signed [TW-1:0]   TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [TW-1:0]   HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [XW-1:0]   GAIN_Q30    = 33'sd652032874;
  localparam logic signed [DIRW-1:0] DIR_LIM     = 35'sd8589934592;
  localparam logic signed [MW-1:0]   COEF_LIM    = 30'sd268435456;

  localparam logic [30:0] ATAN_Q30 [MAX_STEPS] = '{
    31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159, 31'd67021687,
    31'd33543516, 31'd16775851, 31'd8388437, 31'd4194283, 31'd2097149,
    31'd1048576, 31'd524288, 31'd262144, 31'd131072, 31'd65536, 31'd32768,
    31'd16384, 31'd8192, 31'd4096, 31'd2048, 31'd1024, 31'd512, 31'd256,
    31'd128, 31'd64, 31'd32, 31'd16, 31'd8, 31'd4, 31'd2, 31'd1, 31'd0
  };

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // rounded dot product width
  function automatic int dot_w(input int f);
    return 52 - f;
  endfunction

  // rounded projection width
  function automatic int proj_w(input int f);
    return 71 - 2 * f;
  endfunction

  // axis product width once brought to Q26
  function automatic int aa_w(input int f);
    return (2 * f > TRIG_Q) ? 63 - 2 * f : 62 - 2 * f;
  endfunction

  // side data carried along the CORDIC row
  function automatic int pass_w(input int f);
    return 3 * AW + 6 * aa_w(f) + 3 * DIRW + 3 * proj_w(f);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/rpa_front.sv =====
// Front pipeline: projection onto the axis, remainder, axis products and angle reduction.
`timescale 1ns / 1ps
`default_nettype none
module rpa_front #(
  parameter int FRAC_BITS = 16
) (
  input  wire                                       clk_i,
  input  wire                                       rst_ni,
  input  wire                                       in_valid_i,
  output logic                                      in_ready_o,
  input  wire signed [rpa_pkg::PTW-1:0]             point_x_i,
  input  wire signed [rpa_pkg::PTW-1:0]             point_y_i,
  input  wire signed [rpa_pkg::PTW-1:0]             point_z_i,
  input  wire signed [rpa_pkg::AW-1:0]              axis_x_i,
  input  wire signed [rpa_pkg::AW-1:0]              axis_y_i,
  input  wire signed [rpa_pkg::AW-1:0]              axis_z_i,
  input  wire signed [31:0]                         angle_i,
  output logic                                      out_valid_o,
  input  wire                                       out_ready_i,
  output logic signed [rpa_pkg::TW-1:0]             t_o,
  output logic                                      neg_o,
  output logic [rpa_pkg::pass_w(FRAC_BITS)-1:0]     pass_o
);
  import rpa_pkg::*;

  localparam int NS    = 5;
  localparam int PRW   = PTW + AW;
  localparam int SUMW  = 52;
  localparam int AARW  = 2 * AW;
  localparam int DW    = dot_w(FRAC_BITS);
  localparam int PRJRW = AW + DW;
  localparam int PJW   = proj_w(FRAC_BITS);
  localparam int AAW   = aa_w(FRAC_BITS);
  localparam int DFW   = imax(imax(PJW, PTW) + 1, DIRW);
  localparam int TWO_F = 2 * FRAC_BITS;

  localparam logic signed [SUMW-1:0]  RND_DOT  = SUMW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [PRJRW-1:0] RND_PROJ = PRJRW'(1) <<< (FRAC_BITS - 1);

  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = ~v_q[NS-1] | out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = ~v_q[k] | en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];

  logic signed [PTW-1:0] pin [3];
  logic signed [AW-1:0]  ain [3];
  assign pin = '{point_x_i, point_y_i, point_z_i};
  assign ain = '{axis_x_i, axis_y_i, axis_z_i};

  // stage A: products, angle wrap into [-pi, pi]
  logic signed [PRW-1:0]  prod_d [3];
  logic signed [AARW-1:0] aar_d [6];
  logic signed [TW-1:0]   t4, t1_d;
  logic signed [PTW-1:0]  p_a_q [3];
  logic signed [AW-1:0]   a_a_q [3];
  logic signed [PRW-1:0]  prod_a_q [3];
  logic signed [AARW-1:0] aar_a_q [6];
  logic signed [TW-1:0]   t1_a_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_d[i] = PRW'(pin[i]) * PRW'(ain[i]);
    end
    aar_d[0] = AARW'(ain[0]) * AARW'(ain[0]);
    aar_d[1] = AARW'(ain[0]) * AARW'(ain[1]);
    aar_d[2] = AARW'(ain[0]) * AARW'(ain[2]);
    aar_d[3] = AARW'(ain[1]) * AARW'(ain[1]);
    aar_d[4] = AARW'(ain[1]) * AARW'(ain[2]);
    aar_d[5] = AARW'(ain[2]) * AARW'(ain[2]);
    t4 = TW'(angle_i) <<< 2;
    if (t4 > PI_Q30) begin
      t1_d = t4 - TWO_PI_Q30;
    end else if (t4 < -PI_Q30) begin
      t1_d = t4 + TWO_PI_Q30;
    end else begin
      t1_d = t4;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      p_a_q    <= pin;
      a_a_q    <= ain;
      prod_a_q <= prod_d;
      aar_a_q  <= aar_d;
      t1_a_q   <= t1_d;
    end
  end

  // stage B: dot product, axis products to Q26, fold into [-pi/2, pi/2]
  logic signed [SUMW-1:0] sum_b;
  logic signed [DW-1:0]   dot_d;
  logic signed [AAW-1:0]  aat_d [6];
  logic signed [TW-1:0]   t2_d;
  logic                   neg_d;
  logic signed [PTW-1:0]  p_b_q [3];
  logic signed [AW-1:0]   a_b_q [3];
  logic signed [DW-1:0]   dot_b_q;
  logic signed [AAW-1:0]  aat_b_q [6];
  logic signed [TW-1:0]   t2_b_q;
  logic                   neg_b_q;

  always_comb begin
    sum_b = SUMW'(prod_a_q[0]) + SUMW'(prod_a_q[1]) + SUMW'(prod_a_q[2]);
    dot_d = DW'((sum_b + RND_DOT) >>> FRAC_BITS);
    neg_d = 1'b1;
    if (t1_a_q > HALF_PI_Q30) begin
      t2_d = PI_Q30 - t1_a_q;
    end else if (t1_a_q < -HALF_PI_Q30) begin
      t2_d = -PI_Q30 - t1_a_q;
    end else begin
      t2_d  = t1_a_q;
      neg_d = 1'b0;
    end
  end

  if (TWO_F > TRIG_Q) begin : g_aa_down
    localparam int SH = TWO_F - TRIG_Q;
    localparam logic signed [AARW:0] RND_AA = (AARW + 1)'(1) <<< (SH - 1);
    for (genvar k = 0; k < 6; k++) begin : g_k
      assign aat_d[k] = AAW'(((AARW + 1)'(aar_a_q[k]) + RND_AA) >>> SH);
    end
  end else begin : g_aa_up
    for (genvar k = 0; k < 6; k++) begin : g_k
      assign aat_d[k] = AAW'(aar_a_q[k]) <<< (TRIG_Q - TWO_F);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      p_b_q   <= p_a_q;
      a_b_q   <= a_a_q;
      dot_b_q <= dot_d;
      aat_b_q <= aat_d;
      t2_b_q  <= t2_d;
      neg_b_q <= neg_d;
    end
  end

  // stage C: axis times dot
  logic signed [PRJRW-1:0] projr_d [3];
  logic signed [PTW-1:0]   p_c_q [3];
  logic signed [AW-1:0]    a_c_q [3];
  logic signed [AAW-1:0]   aat_c_q [6];
  logic signed [PRJRW-1:0] projr_c_q [3];
  logic signed [TW-1:0]    t_c_q;
  logic                    neg_c_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      projr_d[i] = PRJRW'(a_b_q[i]) * PRJRW'(dot_b_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      p_c_q     <= p_b_q;
      a_c_q     <= a_b_q;
      aat_c_q   <= aat_b_q;
      projr_c_q <= projr_d;
      t_c_q     <= t2_b_q;
      neg_c_q   <= neg_b_q;
    end
  end

  // stage D: round projection
  logic signed [PJW-1:0] proj_d [3];
  logic signed [PTW-1:0] p_d_q [3];
  logic signed [AW-1:0]  a_d_q [3];
  logic signed [AAW-1:0] aat_d_q [6];
  logic signed [PJW-1:0] proj_d_q [3];
  logic signed [TW-1:0]  t_d_q;
  logic                  neg_d_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      proj_d[i] = PJW'((projr_c_q[i] + RND_PROJ) >>> FRAC_BITS);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      p_d_q    <= p_c_q;
      a_d_q    <= a_c_q;
      aat_d_q  <= aat_c_q;
      proj_d_q <= proj_d;
      t_d_q    <= t_c_q;
      neg_d_q  <= neg_c_q;
    end
  end

  // stage E: clamped remainder
  logic signed [DFW-1:0]  diff [3];
  logic signed [DIRW-1:0] dir_d [3];
  logic signed [AW-1:0]   a_e_q [3];
  logic signed [AAW-1:0]  aat_e_q [6];
  logic signed [PJW-1:0]  proj_e_q [3];
  logic signed [DIRW-1:0] dir_e_q [3];
  logic signed [TW-1:0]   t_e_q;
  logic                   neg_e_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = DFW'(p_d_q[i]) - DFW'(proj_d_q[i]);
      if (diff[i] > DFW'(DIR_LIM)) begin
        dir_d[i] = DIR_LIM;
      end else if (diff[i] < -DFW'(DIR_LIM)) begin
        dir_d[i] = -DIR_LIM;
      end else begin
        dir_d[i] = DIRW'(diff[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      a_e_q    <= a_d_q;
      aat_e_q  <= aat_d_q;
      proj_e_q <= proj_d_q;
      dir_e_q  <= dir_d;
      t_e_q    <= t_d_q;
      neg_e_q  <= neg_d_q;
    end
  end

  assign t_o    = t_e_q;
  assign neg_o  = neg_e_q;
  assign pass_o = {a_e_q[0], a_e_q[1], a_e_q[2],
                   aat_e_q[0], aat_e_q[1], aat_e_q[2], aat_e_q[3], aat_e_q[4], aat_e_q[5],
                   dir_e_q[0], dir_e_q[1], dir_e_q[2],
                   proj_e_q[0], proj_e_q[1], proj_e_q[2]};

  // folded angle stays inside the CORDIC convergence range
  a_fold_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[1] |-> (t2_b_q <= HALF_PI_Q30 && t2_b_q >= -HALF_PI_Q30))
    else $error("folded angle out of range");

endmodule
`default_nettype wire

// ===== rtl/core/rpa_cordic_cell.sv =====
// One CORDIC rotation step as a registered cell that also carries side data.
`timescale 1ns / 1ps
`default_nettype none
module rpa_cordic_cell #(
  parameter int STEP = 0,
  parameter int PW   = 1
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  wire signed [rpa_pkg::XW-1:0]  x_i,
  input  wire signed [rpa_pkg::XW-1:0]  y_i,
  input  wire signed [rpa_pkg::TW-1:0]  t_i,
  input  wire [PW-1:0]                  pass_i,
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output logic signed [rpa_pkg::XW-1:0] x_o,
  output logic signed [rpa_pkg::XW-1:0] y_o,
  output logic signed [rpa_pkg::TW-1:0] t_o,
  output logic [PW-1:0]                 pass_o
);
  import rpa_pkg::*;

  logic                 v_q;
  logic                 en;
  logic signed [XW-1:0] xs, ys, x_d, y_d;
  logic signed [TW-1:0] atan, t_d;

  assign en         = ~v_q | out_ready_i;
  assign in_ready_o = en;
  assign atan       = TW'(ATAN_Q30[STEP]);

  always_comb begin
    xs = x_i >>> STEP;
    ys = y_i >>> STEP;
    if (!t_i[TW-1]) begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      t_d = t_i - atan;
    end else begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      t_d = t_i + atan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_o    <= x_d;
      y_o    <= y_d;
      t_o    <= t_d;
      pass_o <= pass_i;
    end
  end

  assign out_valid_o = v_q;

endmodule
`default_nettype wire

// ===== rtl/core/rpa_back.sv =====
// Back pipeline: rotation matrix from sin/cos, matrix times remainder, projection added back.
`timescale 1ns / 1ps
`default_nettype none
module rpa_back #(
  parameter int FRAC_BITS = 16
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   in_valid_i,
  output logic                                  in_ready_o,
  input  wire signed [rpa_pkg::XW-1:0]          x_i,
  input  wire signed [rpa_pkg::XW-1:0]          y_i,
  input  wire                                   neg_i,
  input  wire [rpa_pkg::pass_w(FRAC_BITS)-1:0]  pass_i,
  output logic                                  out_valid_o,
  input  wire                                   out_ready_i,
  output logic signed [rpa_pkg::PTW-1:0]        rotated_x_o,
  output logic signed [rpa_pkg::PTW-1:0]        rotated_y_o,
  output logic signed [rpa_pkg::PTW-1:0]        rotated_z_o,
  output logic                                  saturated_o
);
  import rpa_pkg::*;

  localparam int NS   = 8;
  localparam int XNW  = XW + 1;
  localparam int OW   = CW + 1;
  localparam int ASRW = AW + CW;
  localparam int ASW  = ASRW - FRAC_BITS + 1;
  localparam int AAW  = aa_w(FRAC_BITS);
  localparam int OMRW = OW + AAW;
  localparam int OMW  = OMRW - TRIG_Q + 1;
  localparam int SW   = imax(imax(OMW, ASW), imax(CW, MW)) + 1;
  localparam int PMW  = MW + DIRW;
  localparam int ACW  = PMW + 2;
  localparam int PJW  = proj_w(FRAC_BITS);
  localparam int RW   = imax(ACW - TRIG_Q + 1, PJW) + 1;

  localparam logic signed [XNW-1:0]  RND_CS  = XNW'(1) <<< 3;
  localparam logic signed [ASRW:0]   RND_AS  = (ASRW + 1)'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [OMRW:0]   RND_OM  = (OMRW + 1)'(1) <<< (TRIG_Q - 1);
  localparam logic signed [ACW-1:0]  RND_ACC = ACW'(1) <<< (TRIG_Q - 1);
  localparam logic signed [OW-1:0]   ONE_Q26 = OW'(1) <<< TRIG_Q;
  localparam logic signed [RW-1:0]   SMAX    = RW'(2147483647);
  localparam logic signed [RW-1:0]   SMIN    = ~SMAX;

  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = ~v_q[NS-1] | out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = ~v_q[k] | en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];

  logic signed [AW-1:0]   a_u [3];
  logic signed [AAW-1:0]  aa_u [6];
  logic signed [DIRW-1:0] dir_u [3];
  logic signed [PJW-1:0]  proj_u [3];
  assign {a_u[0], a_u[1], a_u[2], aa_u[0], aa_u[1], aa_u[2], aa_u[3], aa_u[4], aa_u[5],
          dir_u[0], dir_u[1], dir_u[2], proj_u[0], proj_u[1], proj_u[2]} = pass_i;

  // stage 1: cos / sin to Q26
  logic signed [XNW-1:0]  xn;
  logic signed [CW-1:0]   c_d, s_d;
  logic signed [CW-1:0]   c1_q, s1_q;
  logic signed [AW-1:0]   a1_q [3];
  logic signed [AAW-1:0]  aa1_q [6];
  logic signed [DIRW-1:0] dir1_q [3];
  logic signed [PJW-1:0]  proj1_q [3];

  always_comb begin
    xn  = neg_i ? -XNW'(x_i) : XNW'(x_i);
    c_d = CW'((xn + RND_CS) >>> 4);
    s_d = CW'((XNW'(y_i) + RND_CS) >>> 4);
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      c1_q <= c_d; s1_q <= s_d; a1_q <= a_u; aa1_q <= aa_u;
      dir1_q <= dir_u; proj1_q <= proj_u;
    end
  end

  // stage 2: 1 - cos, axis times sin
  logic signed [ASRW-1:0] asr_d [3];
  logic signed [CW-1:0]   c2_q;
  logic signed [OW-1:0]   omc2_q;
  logic signed [ASRW-1:0] asr2_q [3];
  logic signed [AAW-1:0]  aa2_q [6];
  logic signed [DIRW-1:0] dir2_q [3];
  logic signed [PJW-1:0]  proj2_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      asr_d[i] = ASRW'(a1_q[i]) * ASRW'(s1_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      c2_q <= c1_q; omc2_q <= ONE_Q26 - OW'(c1_q); asr2_q <= asr_d; aa2_q <= aa1_q;
      dir2_q <= dir1_q; proj2_q <= proj1_q;
    end
  end

  // stage 3: (1 - cos) * a*b, round axis*sin
  logic signed [OMRW-1:0] omr_d [6];
  logic signed [ASW-1:0]  as_d [3];
  logic signed [CW-1:0]   c3_q;
  logic signed [OMRW-1:0] omr3_q [6];
  logic signed [ASW-1:0]  as3_q [3];
  logic signed [DIRW-1:0] dir3_q [3];
  logic signed [PJW-1:0]  proj3_q [3];

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      omr_d[k] = OMRW'(omc2_q) * OMRW'(aa2_q[k]);
    end
    for (int i = 0; i < 3; i++) begin
      as_d[i] = ASW'(((ASRW + 1)'(asr2_q[i]) + RND_AS) >>> FRAC_BITS);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      c3_q <= c2_q; omr3_q <= omr_d; as3_q <= as_d;
      dir3_q <= dir2_q; proj3_q <= proj2_q;
    end
  end

  // stage 4: round (1 - cos) * a*b
  logic signed [OMW-1:0]  om_d [6];
  logic signed [CW-1:0]   c4_q;
  logic signed [OMW-1:0]  om4_q [6];
  logic signed [ASW-1:0]  as4_q [3];
  logic signed [DIRW-1:0] dir4_q [3];
  logic signed [PJW-1:0]  proj4_q [3];

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      om_d[k] = OMW'(((OMRW + 1)'(omr3_q[k]) + RND_OM) >>> TRIG_Q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      c4_q <= c3_q; om4_q <= om_d; as4_q <= as3_q;
      dir4_q <= dir3_q; proj4_q <= proj3_q;
    end
  end

  // stage 5: nine coefficients, clamped to +-4.0
  function automatic logic signed [MW-1:0] clamp_coef(input logic signed [SW-1:0] v);
    if (v > SW'(COEF_LIM)) return COEF_LIM;
    if (v < -SW'(COEF_LIM)) return -COEF_LIM;
    return MW'(v);
  endfunction

  logic signed [SW-1:0]   cs, o [6], s [3];
  logic signed [MW-1:0]   m_d [9];
  logic signed [MW-1:0]   m5_q [9];
  logic signed [DIRW-1:0] dir5_q [3];
  logic signed [PJW-1:0]  proj5_q [3];

  always_comb begin
    cs = SW'(c4_q);
    for (int k = 0; k < 6; k++) o[k] = SW'(om4_q[k]);
    for (int i = 0; i < 3; i++) s[i] = SW'(as4_q[i]);
    // o: xx, xy, xz, yy, yz, zz
    m_d[0] = clamp_coef(cs + o[0]);
    m_d[1] = clamp_coef(o[1] - s[2]);
    m_d[2] = clamp_coef(o[2] + s[1]);
    m_d[3] = clamp_coef(o[1] + s[2]);
    m_d[4] = clamp_coef(cs + o[3]);
    m_d[5] = clamp_coef(o[4] - s[0]);
    m_d[6] = clamp_coef(o[2] - s[1]);
    m_d[7] = clamp_coef(o[4] + s[0]);
    m_d[8] = clamp_coef(cs + o[5]);
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      m5_q <= m_d; dir5_q <= dir4_q; proj5_q <= proj4_q;
    end
  end

  // stage 6: coefficient times remainder
  logic signed [PMW-1:0] pm_d [9];
  logic signed [PMW-1:0] pm6_q [9];
  logic signed [PJW-1:0] proj6_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pm_d[i*3+j] = PMW'(m5_q[i*3+j]) * PMW'(dir5_q[j]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      pm6_q <= pm_d; proj6_q <= proj5_q;
    end
  end

  // stage 7: row sums
  logic signed [ACW-1:0] acc_d [3];
  logic signed [ACW-1:0] acc7_q [3];
  logic signed [PJW-1:0] proj7_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc_d[i] = ACW'(pm6_q[i*3]) + ACW'(pm6_q[i*3+1]) + ACW'(pm6_q[i*3+2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      acc7_q <= acc_d; proj7_q <= proj6_q;
    end
  end

  // stage 8: round, add projection back, saturate
  logic signed [RW-1:0]  r [3];
  logic signed [PTW-1:0] res_d [3];
  logic                  sat_d;
  logic signed [PTW-1:0] res8_q [3];
  logic                  sat8_q;

  always_comb begin
    sat_d = 1'b0;
    for (int i = 0; i < 3; i++) begin
      r[i] = RW'((acc7_q[i] + RND_ACC) >>> TRIG_Q) + RW'(proj7_q[i]);
      if (r[i] > SMAX) begin
        res_d[i] = PTW'(SMAX);
        sat_d    = 1'b1;
      end else if (r[i] < SMIN) begin
        res_d[i] = PTW'(SMIN);
        sat_d    = 1'b1;
      end else begin
        res_d[i] = PTW'(r[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      res8_q <= res_d; sat8_q <= sat_d;
    end
  end

  assign rotated_x_o = res8_q[0];
  assign rotated_y_o = res8_q[1];
  assign rotated_z_o = res8_q[2];
  assign saturated_o = sat8_q;

endmodule
`default_nettype wire

// ===== rtl/core/rotate_point_about_axis.sv =====
// Top level: rotates a Q16.16 point about an axis through the origin (Rodrigues form).
`timescale 1ns / 1ps
`default_nettype none
// Usage
//   Input channel in_valid_i / in_ready_o carries one request: point, axis
//   (taken as given, not normalized) and angle in radians, Q4.28.
//   Output channel out_valid_o / out_ready_i returns the rotated point,
//   saturated to 32 bits, with saturated_o set when any coordinate clipped.
// Stages: 5 front stages for projection and angle reduction, one registered
//   cell per CORDIC step (CORDIC_STEPS, at most 32), 8 back stages for the
//   matrix, the row sums and the final rounding and saturation.
// Throughput: one request per cycle while out_ready_i is high; every stage is
//   a register with its own valid bit, so a new request enters each cycle.
// Stall: when out_ready_i is low the last stage holds its result; empty
//   stages further up keep filling, and in_ready_o drops only once every
//   stage holds a request.
// Reset: rst_ni (async, active low) empties all stages; no other state.
module rotate_point_about_axis #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 24
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  wire signed [31:0] point_x_i,
  input  wire signed [31:0] point_y_i,
  input  wire signed [31:0] point_z_i,
  input  wire signed [17:0] axis_x_i,
  input  wire signed [17:0] axis_y_i,
  input  wire signed [17:0] axis_z_i,
  input  wire signed [31:0] angle_i,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output logic signed [31:0] rotated_x_o,
  output logic signed [31:0] rotated_y_o,
  output logic signed [31:0] rotated_z_o,
  output logic              saturated_o
);
  import rpa_pkg::*;

  localparam int N      = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
  localparam int PASS_W = pass_w(FRAC_BITS);
  localparam int CPW    = PASS_W + 1;  // side data plus cosine sign

  logic                 cv [N+1];
  logic                 cr [N+1];
  logic signed [XW-1:0] cx [N+1];
  logic signed [XW-1:0] cy [N+1];
  logic signed [TW-1:0] ct [N+1];
  logic [CPW-1:0]       cp [N+1];

  logic                 f_neg;
  logic [PASS_W-1:0]    f_pass;

  rpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .point_x_i   (point_x_i),
    .point_y_i   (point_y_i),
    .point_z_i   (point_z_i),
    .axis_x_i    (axis_x_i),
    .axis_y_i    (axis_y_i),
    .axis_z_i    (axis_z_i),
    .angle_i     (angle_i),
    .out_valid_o (cv[0]),
    .out_ready_i (cr[0]),
    .t_o         (ct[0]),
    .neg_o       (f_neg),
    .pass_o      (f_pass)
  );

  // CORDIC starts at the gain constant on the x axis
  assign cx[0] = GAIN_Q30;
  assign cy[0] = '0;
  assign cp[0] = {f_neg, f_pass};

  for (genvar i = 0; i < N; i++) begin : g_cell
    rpa_cordic_cell #(.STEP(i), .PW(CPW)) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (cv[i]),
      .in_ready_o  (cr[i]),
      .x_i         (cx[i]),
      .y_i         (cy[i]),
      .t_i         (ct[i]),
      .pass_i      (cp[i]),
      .out_valid_o (cv[i+1]),
      .out_ready_i (cr[i+1]),
      .x_o         (cx[i+1]),
      .y_o         (cy[i+1]),
      .t_o         (ct[i+1]),
      .pass_o      (cp[i+1])
    );
  end

  rpa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cv[N]),
    .in_ready_o  (cr[N]),
    .x_i         (cx[N]),
    .y_i         (cy[N]),
    .neg_i       (cp[N][CPW-1]),
    .pass_i      (cp[N][PASS_W-1:0]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .rotated_x_o (rotated_x_o),
    .rotated_y_o (rotated_y_o),
    .rotated_z_o (rotated_z_o),
    .saturated_o (saturated_o)
  );

  localparam logic signed [31:0] OUT_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] OUT_MIN = 32'sh80000000;

  // with the last stage free to drain, the whole chain must take a request
  a_ready_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ready_i || !out_valid_o) |-> in_ready_o)
    else $error("in_ready_o low while output drains");

  // a clipped result shows a coordinate at a limit
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |->
      (rotated_x_o == OUT_MAX || rotated_x_o == OUT_MIN ||
       rotated_y_o == OUT_MAX || rotated_y_o == OUT_MIN ||
       rotated_z_o == OUT_MAX || rotated_z_o == OUT_MIN))
    else $error("saturated_o set with no coordinate at a limit");

endmodule
`default_nettype wire
